>>> rtl/keyed_burst_coalescer_top_macros.svh
// assertion macros shared by the keyed burst coalescer rtl
`ifndef KEYED_BURST_COALESCER_TOP_MACROS_SVH
`define KEYED_BURST_COALESCER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked at every rising edge out of reset
`define KBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define KBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define KBC_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define KBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/kbc_pkg.sv
// types and constants of the keyed burst coalescer
package kbc_pkg;

   localparam int SRC_W    = 8;
   localparam int TGT_W    = 8;
   localparam int AMT_W    = 12;
   localparam int SUM_W    = 16;
   localparam int TICK_W   = 16;
   localparam int AGE_W    = 8;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
   localparam logic [AGE_W-1:0] MIN_AGE_RESET = 8'd4;

   // request kinds carried on tuser
   localparam logic REQ_HIT  = 1'b0;
   localparam logic REQ_TICK = 1'b1;

   // result kinds carried on tuser
   localparam logic KIND_BURST = 1'b0;
   localparam logic KIND_DROP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   // one open burst
   typedef struct packed {
      logic [SRC_W-1:0]  src;
      logic [TGT_W-1:0]  tgt;
      logic [SUM_W-1:0]  sum;
      logic              fr;
      logic [TICK_W-1:0] stamp;
   } entry_type;

   // control broadcast from the top level to every cell
   typedef struct packed {
      logic              insert;
      logic              merge;
      logic              scan_step;
      logic              keep_head;
      logic [SRC_W-1:0]  src;
      logic [TGT_W-1:0]  tgt;
      logic [AMT_W-1:0]  amt;
      logic              fr;
   } cell_ctl_type;

endpackage

>>> rtl/kbc_cell.sv
// one burst cell of the coalescer chain
module kbc_cell (
   input  logic                  clock,
   input  kbc_pkg::cell_ctl_type ctl,
   input  logic                  occupied,
   input  logic                  is_tail,
   input  kbc_pkg::entry_type    lower,
   input  kbc_pkg::entry_type    upper,
   input  kbc_pkg::entry_type    head,
   output kbc_pkg::entry_type    entry,
   output logic                  match
);

   kbc_pkg::entry_type           entry_ff;
   kbc_pkg::entry_type           entry_in;
   logic [kbc_pkg::SUM_W:0]      sum_ext;

   // key compare and next entry
   always_comb begin
      match    = occupied && (entry_ff.src == ctl.src) && (entry_ff.tgt == ctl.tgt);
      sum_ext  = {1'b0, entry_ff.sum}
               + {{(kbc_pkg::SUM_W + 1 - kbc_pkg::AMT_W){1'b0}}, ctl.amt};
      entry_in = entry_ff;
      if (ctl.insert) begin
         // new burst enters at the newest end, the rest move one place older
         entry_in = lower;
      end else if (ctl.merge && match) begin
         entry_in.sum = sum_ext[kbc_pkg::SUM_W] ? kbc_pkg::SUM_MAX
                                                : sum_ext[kbc_pkg::SUM_W-1:0];
         entry_in.fr  = ctl.fr;
      end else if (ctl.scan_step) begin
         // scan moves the row one place newer, kept head wraps to the tail
         entry_in = (is_tail && ctl.keep_head) ? head : upper;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

>>> rtl/keyed_burst_coalescer_top.sv
// keyed burst coalescer: hits merge into a row of burst cells, ticks emit matured bursts
// a dropped hit shows its result on the next cycle
// a tick scans the open bursts one cell per cycle then flushes,
// one beat per matured burst, the last one set up by the flush; a stalled sink stalls the scan
// reset clears the burst count, tick counter and control, min age returns to 4; cells hold
`include "keyed_burst_coalescer_top_macros.svh"
module keyed_burst_coalescer_top #(
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // source_id[7:0], target_id[15:8], amount[27:16], friendly[28], zero fill
   input  logic [kbc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type
   input  logic                             req_tuser,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // out_source[7:0], out_target[15:8], total[31:16], out_friendly[32], zero fill
   output logic [kbc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // kind
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_wr_en,
   input  logic [kbc_pkg::AGE_W-1:0]        csr_wr_data
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   kbc_pkg::state_type              state_ff, state_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [CNT_W-1:0]                remain_ff, remain_in;
   logic [kbc_pkg::TICK_W-1:0]      now_ff, now_in;
   logic [kbc_pkg::AGE_W-1:0]       min_age_ff;
   logic                            pend_vld_ff, pend_vld_in;
   kbc_pkg::entry_type              pend_ff, pend_in;
   logic                            rsp_vld_ff, rsp_vld_in;
   logic [kbc_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                            rsp_kind_ff, rsp_kind_in;
   logic                            rsp_last_ff, rsp_last_in;

   kbc_pkg::cell_ctl_type           ctl;
   kbc_pkg::entry_type              cell_q [DEPTH];
   kbc_pkg::entry_type              new_entry;
   kbc_pkg::entry_type              head;
   logic [DEPTH-1:0]                match_vec;
   logic                            any_match;
   logic                            full;
   logic                            out_free;
   logic                            req_acc;
   logic                            hit_acc;
   logic                            tick_acc;
   logic                            step;
   logic                            ripe;
   logic [kbc_pkg::TICK_W-1:0]      age;

   // request field decode
   assign new_entry.src   = req_tdata[7:0];
   assign new_entry.tgt   = req_tdata[15:8];
   assign new_entry.sum   = {{(kbc_pkg::SUM_W - kbc_pkg::AMT_W){1'b0}}, req_tdata[27:16]};
   assign new_entry.fr    = req_tdata[28];
   assign new_entry.stamp = now_ff;

   assign head      = cell_q[0];
   assign any_match = |match_vec;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign out_free  = !rsp_vld_ff || rsp_tready;
   assign req_tready = (state_ff == kbc_pkg::ST_IDLE) && out_free;
   assign req_acc   = req_tvalid && req_tready;
   assign hit_acc   = req_acc && (req_tuser == kbc_pkg::REQ_HIT);
   assign tick_acc  = req_acc && (req_tuser == kbc_pkg::REQ_TICK);
   assign step      = (state_ff == kbc_pkg::ST_SCAN) && (remain_ff != '0) && out_free;

   // age of the head burst against the advanced tick count
   assign age  = now_ff - head.stamp;
   assign ripe = age >= {{(kbc_pkg::TICK_W - kbc_pkg::AGE_W){1'b0}}, min_age_ff};

   // broadcast control for the row
   always_comb begin
      ctl.insert    = hit_acc && !any_match && !full;
      ctl.merge     = hit_acc;
      ctl.scan_step = step;
      ctl.keep_head = !ripe;
      ctl.src       = new_entry.src;
      ctl.tgt       = new_entry.tgt;
      ctl.amt       = req_tdata[27:16];
      ctl.fr        = new_entry.fr;
   end

   // row of burst cells, newest at cell 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      kbc_pkg::entry_type lower_w;
      kbc_pkg::entry_type upper_w;
      if (i == 0) begin : g_first
         assign lower_w = new_entry;
      end else begin : g_mid_lo
         assign lower_w = cell_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign upper_w = head;
      end else begin : g_mid_hi
         assign upper_w = cell_q[i+1];
      end
      kbc_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .occupied (count_ff > CNT_W'(i)),
         .is_tail  (count_ff == CNT_W'(i + 1)),
         .lower    (lower_w),
         .upper    (upper_w),
         .head     (head),
         .entry    (cell_q[i]),
         .match    (match_vec[i])
      );
   end

   // sequencer, pending beat and output register
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      remain_in   = remain_ff;
      now_in      = now_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         kbc_pkg::ST_IDLE: begin
            if (hit_acc && !any_match) begin
               if (!full) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  // dropped hit reported straight away
                  rsp_vld_in  = 1'b1;
                  rsp_kind_in = kbc_pkg::KIND_DROP;
                  rsp_last_in = 1'b1;
                  rsp_data_in = {7'd0, new_entry.fr, new_entry.sum,
                                 new_entry.tgt, new_entry.src};
               end
            end else if (tick_acc) begin
               now_in    = now_ff + kbc_pkg::TICK_W'(1);
               remain_in = count_ff;
               state_in  = kbc_pkg::ST_SCAN;
            end
         end
         kbc_pkg::ST_SCAN: begin
            if (step) begin
               remain_in = remain_ff - CNT_W'(1);
               if (ripe) begin
                  count_in    = count_ff - CNT_W'(1);
                  pend_vld_in = 1'b1;
                  pend_in     = head;
                  if (pend_vld_ff) begin
                     rsp_vld_in  = 1'b1;
                     rsp_kind_in = kbc_pkg::KIND_BURST;
                     rsp_last_in = 1'b0;
                     rsp_data_in = {7'd0, pend_ff.fr, pend_ff.sum, pend_ff.tgt, pend_ff.src};
                  end
               end
            end else if ((remain_ff == '0) && out_free) begin
               // flush the held burst as the final beat
               if (pend_vld_ff) begin
                  rsp_vld_in  = 1'b1;
                  rsp_kind_in = kbc_pkg::KIND_BURST;
                  rsp_last_in = 1'b1;
                  rsp_data_in = {7'd0, pend_ff.fr, pend_ff.sum, pend_ff.tgt, pend_ff.src};
               end
               pend_vld_in = 1'b0;
               state_in    = kbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kbc_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= kbc_pkg::ST_IDLE;
         count_ff    <= '0;
         remain_ff   <= '0;
         now_ff      <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         min_age_ff  <= kbc_pkg::MIN_AGE_RESET;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         remain_ff   <= remain_in;
         now_ff      <= now_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (csr_wr_en) begin
            min_age_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `KBC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "burst count above depth")
   `KBC_ASSERT_NOW(a_remain_bound, clock, reset, state_ff == kbc_pkg::ST_SCAN, remain_ff <= count_ff, "scan remainder above burst count")
   `KBC_ASSERT_NOW(a_pend_idle, clock, reset, state_ff == kbc_pkg::ST_IDLE, !pend_vld_ff, "held burst left over after scan")
   `KBC_ASSERT_NEXT(a_tick_start, clock, reset, tick_acc, (state_ff == kbc_pkg::ST_SCAN) && (remain_ff == $past(count_ff)), "tick did not start a full scan")
   `KBC_ASSERT_NEXT(a_idle_count, clock, reset, (state_ff == kbc_pkg::ST_IDLE) && !req_acc, count_ff == $past(count_ff), "burst count moved while idle")

endmodule
